[rtl/killer_history_move_table_assert.svh]
// assertion macros for the killer/history move table
// expects i_clk and i_rst_n in the including scope
`ifndef KILLER_HISTORY_MOVE_TABLE_ASSERT_SVH
`define KILLER_HISTORY_MOVE_TABLE_ASSERT_SVH

// property checked on every clock edge outside reset
`define KHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// consequence checked in the cycle after the trigger
`define KHT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

[rtl/kht_pkg.sv]
// shared types and constants for the killer/history move table
// no dependencies
package kht_pkg;

    localparam int C_SQUARES       = 64;
    localparam int C_SIDES         = 2;
    localparam int C_MAX_PLY       = 64;
    localparam int C_SCORE_CEILING = 1 << 24;

    localparam int C_MOVE_W   = 16;
    localparam int C_SQUARE_W = 6;
    localparam int C_PLY_W    = 6;
    localparam int C_DEPTH_W  = 6;
    localparam int C_SQ_W     = 2 * C_DEPTH_W;
    localparam int C_RES_W    = 31;

    // largest depth squared that one cutoff adds
    localparam int C_MAX_ADD = ((1 << C_DEPTH_W) - 1) * ((1 << C_DEPTH_W) - 1);

    localparam int C_HIST_DEPTH = C_SIDES * C_SQUARES * C_SQUARES;
    localparam int C_HIST_AW    = $clog2(C_HIST_DEPTH);

    typedef enum logic {
        KIND_RECORD = 1'b0,
        KIND_QUERY  = 1'b1
    } t_kind;

    typedef logic [C_MOVE_W-1:0]   t_move_code;
    typedef logic [C_SQUARE_W-1:0] t_square;
    typedef logic [C_PLY_W-1:0]    t_ply;
    typedef logic [C_DEPTH_W-1:0]  t_depth;
    typedef logic [C_RES_W-1:0]    t_priority;

    localparam t_priority C_TOP_PRIORITY    = {C_RES_W{1'b1}};
    localparam t_priority C_SECOND_PRIORITY = C_TOP_PRIORITY - t_priority'(1);

endpackage

[rtl/kht_if.sv]
// valid/ready channel interfaces for the killer/history move table
// depends on kht_pkg
interface kht_in_if;
    import kht_pkg::*;

    logic       valid;
    logic       ready;
    t_kind      kind;
    t_move_code move_code;
    logic       side;
    t_square    from_square;
    t_square    to_square;
    t_ply       ply;
    t_depth     depth;

    modport source (
        output valid, kind, move_code, side, from_square, to_square, ply, depth,
        input  ready
    );
    modport sink (
        input  valid, kind, move_code, side, from_square, to_square, ply, depth,
        output ready
    );
endinterface

interface kht_out_if;
    import kht_pkg::*;

    logic      valid;
    logic      ready;
    t_priority priority_res;

    modport source (output valid, priority_res, input ready);
    modport sink   (input valid, priority_res, output ready);
endinterface

[rtl/kht_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module kht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/killer_history_move_table.sv]
// killer/history move table: a query result is registered on leaving exec, held while stalled;
// exec waits while an earlier result is untaken, and a new transaction is taken only once the
// read-modify-write of the history memory is through; a cutoff whose score passes the ceiling
// starts a halving sweep over all HIST_DEPTH entries during which no transaction is taken
// after reset a clearing pass over HIST_DEPTH entries (8192) zeroes the history memory first;
// reset is synchronous, active low, and empties all killer slots at once
`include "killer_history_move_table_assert.svh"

module killer_history_move_table #(
    parameter int MAX_PLY       = kht_pkg::C_MAX_PLY,
    parameter int SCORE_CEILING = kht_pkg::C_SCORE_CEILING
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kht_in_if.sink     i_item,
    kht_out_if.source  o_result
);
    import kht_pkg::*;

    // history memory geometry: scores stay at or below the ceiling plus one cutoff
    localparam int HIST_DEPTH = C_HIST_DEPTH;
    localparam int HIST_AW    = C_HIST_AW;
    localparam int HIST_W     = $clog2(SCORE_CEILING + C_MAX_ADD + 1);

    // killer memory: one row per ply holds {first, second}
    localparam int KILL_W = 2 * C_MOVE_W;
    localparam int PLY_AW = $clog2(MAX_PLY);
    localparam int PLY_XW = (PLY_AW > C_PLY_W) ? PLY_AW : C_PLY_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } t_state;

    t_state             r_state;
    logic [HIST_AW:0]   r_cnt;
    logic               r_out_valid;
    t_priority          r_out_res;
    logic [MAX_PLY-1:0] r_first_valid;
    logic [MAX_PLY-1:0] r_second_valid;

    // captured transaction
    t_kind              r_kind;
    t_move_code         r_move;
    logic [PLY_AW-1:0]  r_ply_addr;
    logic               r_ply_ok;
    logic [C_SQ_W-1:0]  r_sq;
    logic [HIST_AW-1:0] r_hidx;

    // memory ports
    logic               hist_wr_en;
    logic [HIST_AW-1:0] hist_wr_addr;
    logic [HIST_W-1:0]  hist_wr_data;
    logic               hist_rd_en;
    logic [HIST_AW-1:0] hist_rd_addr;
    logic [HIST_W-1:0]  hist_rd_data;
    logic               kill_wr_en;
    logic [KILL_W-1:0]  kill_wr_data;
    logic [KILL_W-1:0]  kill_rd_data;

    logic               accept;
    logic [PLY_XW-1:0]  ply_ext;
    logic [PLY_AW-1:0]  ply_addr_in;
    logic [HIST_AW-1:0] hidx_in;
    t_move_code         kill_first;
    t_move_code         kill_second;
    logic               first_hit;
    logic               second_hit;
    logic [HIST_W-1:0]  hist_sum;
    logic               overflow;
    logic               out_free;
    t_priority          query_res;
    logic [HIST_AW:0]   cnt_m1;

    // a transaction enters only in idle: no clearing, no sweep, no item in flight
    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;

    // history index is side, origin, target packed high to low
    assign hidx_in     = HIST_AW'({i_item.side, i_item.from_square, i_item.to_square});
    assign ply_ext     = PLY_XW'(i_item.ply);
    assign ply_addr_in = ply_ext[PLY_AW-1:0];

    // killer row as read back for the captured ply
    assign kill_first  = kill_rd_data[KILL_W-1:C_MOVE_W];
    assign kill_second = kill_rd_data[C_MOVE_W-1:0];

    // an empty slot matches nothing; a ply past the table has no killers
    assign first_hit  = r_ply_ok && r_first_valid[r_ply_addr] && (kill_first == r_move);
    assign second_hit = r_ply_ok && r_second_valid[r_ply_addr] && (kill_second == r_move);

    assign hist_sum = hist_rd_data + HIST_W'(r_sq);
    assign overflow = hist_sum > HIST_W'(SCORE_CEILING);
    assign out_free = !r_out_valid || o_result.ready;
    assign cnt_m1   = r_cnt - (HIST_AW + 1)'(1);

    always_comb begin
        priority if (first_hit) begin
            query_res = C_TOP_PRIORITY;
        end else if (second_hit) begin
            query_res = C_SECOND_PRIORITY;
        end else begin
            query_res = C_RES_W'(hist_rd_data);
        end
    end

    // memory control per state
    always_comb begin
        hist_wr_en   = 1'b0;
        hist_wr_addr = r_hidx;
        hist_wr_data = hist_sum;
        hist_rd_en   = 1'b0;
        hist_rd_addr = hidx_in;
        kill_wr_en   = 1'b0;
        // new move goes first, old first slides into second
        kill_wr_data = {r_move, kill_first};
        unique case (r_state)
            S_CLEAR: begin
                hist_wr_en   = 1'b1;
                hist_wr_addr = r_cnt[HIST_AW-1:0];
                hist_wr_data = '0;
            end
            S_IDLE: begin
                hist_rd_en = accept;
            end
            S_EXEC: begin
                if (r_kind == KIND_RECORD) begin
                    hist_wr_en = 1'b1;
                    kill_wr_en = r_ply_ok && !first_hit;
                end
            end
            S_SWEEP: begin
                // read entry r_cnt while writing back entry r_cnt - 1 halved
                hist_rd_en   = !r_cnt[HIST_AW];
                hist_rd_addr = r_cnt[HIST_AW-1:0];
                hist_wr_en   = (r_cnt != '0);
                hist_wr_addr = cnt_m1[HIST_AW-1:0];
                hist_wr_data = hist_rd_data >> 1;
            end
        endcase
    end

    // transaction capture, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= i_item.kind;
            r_move     <= i_item.move_code;
            r_ply_addr <= ply_addr_in;
            r_ply_ok   <= int'(i_item.ply) < MAX_PLY;
            r_sq       <= C_SQ_W'(i_item.depth) * C_SQ_W'(i_item.depth);
            r_hidx     <= hidx_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_first_valid  <= '0;
            r_second_valid <= '0;
        end else begin
            // a query leaving exec reloads the result register itself
            if (o_result.valid && o_result.ready
                && !((r_state == S_EXEC) && (r_kind == KIND_QUERY))) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == (HIST_AW + 1)'(HIST_DEPTH - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + (HIST_AW + 1)'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_kind == KIND_QUERY) begin
                        // hold here while an earlier result still waits
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_res   <= query_res;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        if (kill_wr_en) begin
                            r_second_valid[r_ply_addr] <= r_first_valid[r_ply_addr];
                            r_first_valid[r_ply_addr]  <= 1'b1;
                        end
                        if (overflow) begin
                            r_cnt   <= '0;
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_cnt == (HIST_AW + 1)'(HIST_DEPTH)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + (HIST_AW + 1)'(1);
                    end
                end
            endcase
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.priority_res = r_out_res;

    // history scores, cleared after reset and halved in place on overflow
    kht_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (hist_wr_data),
        .i_rd_en   (hist_rd_en),
        .i_rd_addr (hist_rd_addr),
        .o_rd_data (hist_rd_data)
    );

    // killer pairs, contents qualified by the slot valid bits
    kht_ram #(
        .WIDTH (KILL_W),
        .DEPTH (MAX_PLY)
    ) u_killer_ram (
        .i_clk     (i_clk),
        .i_wr_en   (kill_wr_en),
        .i_wr_addr (r_ply_addr),
        .i_wr_data (kill_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (ply_addr_in),
        .o_rd_data (kill_rd_data)
    );

    // checks on the sequencing of the history memory
    `KHT_ASSERT(a_no_idle_write, (r_state == S_IDLE) |-> !hist_wr_en, "history written while idle")
    `KHT_ASSERT_NEXT(a_overflow_sweep, (r_state == S_EXEC) && (r_kind == KIND_RECORD) && overflow, (r_state == S_SWEEP) && (r_cnt == '0), "overflow did not start a halving sweep")
    `KHT_ASSERT(a_sweep_bound, (r_state == S_SWEEP) && hist_wr_en |-> (hist_wr_data <= HIST_W'(SCORE_CEILING)), "halved score above ceiling")

endmodule

[dv/killer_history_move_table_test.sv]
// testbench for killer_history_move_table: random and directed cutoffs and queries,
// results checked against a behavioral predictor of killer slots and history scores
// depends on kht_pkg (rtl/kht_pkg.sv), kht_in_if and kht_out_if (rtl/kht_if.sv)
module killer_history_move_table_test;
    import kht_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        t_kind      kind;
        t_move_code move_code;
        logic       side;
        t_square    from_square;
        t_square    to_square;
        t_ply       ply;
        t_depth     depth;
    } t_table_item;

    // predictor of the block: killer pairs per ply, history scores per side/from/to
    class priority_scoreboard;
        bit [24:0]   hist_score[C_HIST_DEPTH];
        t_move_code  first_move[C_MAX_PLY];
        t_move_code  second_move[C_MAX_PLY];
        bit          first_live[C_MAX_PLY];
        bit          second_live[C_MAX_PLY];
        t_priority   expected_priorities[$];
        int unsigned failures;

        function new();
            foreach (hist_score[i]) hist_score[i] = '0;
            foreach (first_move[i]) begin
                first_move[i]  = '0;
                second_move[i] = '0;
                first_live[i]  = 1'b0;
                second_live[i] = 1'b0;
            end
            failures = 0;
        endfunction

        // update the state for an accepted input transaction
        function void note_item(t_table_item it);
            int unsigned slot;
            bit          ply_ok;
            slot   = 32'({it.side, it.from_square, it.to_square});
            ply_ok = int'(it.ply) < C_MAX_PLY;
            if (it.kind == KIND_QUERY) begin
                if (ply_ok && first_live[it.ply] && first_move[it.ply] == it.move_code) begin
                    expected_priorities.push_back(C_TOP_PRIORITY);
                end else if (ply_ok && second_live[it.ply]
                             && second_move[it.ply] == it.move_code) begin
                    expected_priorities.push_back(C_SECOND_PRIORITY);
                end else begin
                    expected_priorities.push_back(t_priority'(hist_score[slot]));
                end
            end else begin
                // a move already first leaves the pair alone
                if (ply_ok && !(first_live[it.ply] && first_move[it.ply] == it.move_code)) begin
                    second_move[it.ply] = first_move[it.ply];
                    second_live[it.ply] = first_live[it.ply];
                    first_move[it.ply]  = it.move_code;
                    first_live[it.ply]  = 1'b1;
                end
                hist_score[slot] = hist_score[slot] + 25'(it.depth) * 25'(it.depth);
                // past the ceiling every score halves, the raised one included
                if (hist_score[slot] > C_SCORE_CEILING) begin
                    foreach (hist_score[i]) hist_score[i] = hist_score[i] >> 1;
                end
            end
        endfunction

        // compare an accepted result transaction with the oldest expectation
        function void check_result(t_priority got);
            t_priority want;
            if (expected_priorities.size() == 0) begin
                if (failures < 10) $display("unexpected result: priority %0d", got);
                failures++;
            end else begin
                want = expected_priorities.pop_front();
                if (got !== want) begin
                    if (failures < 10) begin
                        $display("priority mismatch: expected %0d, got %0d", want, got);
                    end
                    failures++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    kht_in_if  item_if ();
    kht_out_if result_if ();

    killer_history_move_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    priority_scoreboard sb;

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned cycle_count = 0;

    // small pools so that killer hits and history buildup happen often
    t_move_code move_pool[8];
    logic       entry_side[6];
    t_square    entry_from[6];
    t_square    entry_to[6];

    int unsigned send_idle_by_phase[4] = '{0, 59, 0, 35};
    int unsigned recv_stall_by_phase[4] = '{0, 0, 59, 35};

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[killer_history_move_table] ERROR");
            $finish;
        end
    end

    // result side: check accepted transactions, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            sb.check_result(result_if.priority_res);
        end
        result_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic t_table_item mk_item(t_kind k, t_move_code m, logic s, t_square f,
                                            t_square t, t_ply p, t_depth d);
        t_table_item it;
        it.kind        = k;
        it.move_code   = m;
        it.side        = s;
        it.from_square = f;
        it.to_square   = t;
        it.ply         = p;
        it.depth       = d;
        return it;
    endfunction

    // about half pooled moves, plies and squares; the rest fully random so every bit toggles
    function automatic t_table_item rand_item();
        t_table_item it;
        int unsigned e;
        it.kind      = ($urandom_range(99) < 45) ? KIND_RECORD : KIND_QUERY;
        it.move_code = $urandom_range(1) ? move_pool[$urandom_range(7)] : t_move_code'($urandom);
        it.ply       = $urandom_range(1) ? t_ply'($urandom_range(7)) : t_ply'($urandom_range(63));
        if ($urandom_range(1)) begin
            e = $urandom_range(5);
            it.side        = entry_side[e];
            it.from_square = entry_from[e];
            it.to_square   = entry_to[e];
        end else begin
            it.side        = 1'($urandom_range(1));
            it.from_square = t_square'($urandom_range(63));
            it.to_square   = t_square'($urandom_range(63));
        end
        it.depth = t_depth'($urandom_range(63));
        return it;
    endfunction

    // present one transaction after random idle cycles and wait for the handshake
    task automatic apply_item(input t_table_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.kind        <= it.kind;
        item_if.move_code   <= it.move_code;
        item_if.side        <= it.side;
        item_if.from_square <= it.from_square;
        item_if.to_square   <= it.to_square;
        item_if.ply         <= it.ply;
        item_if.depth       <= it.depth;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        sb.note_item(it);
    endtask

    initial begin
        sb = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        foreach (move_pool[i]) move_pool[i] = t_move_code'($urandom);
        move_pool[0] = '0;
        move_pool[1] = '1;
        foreach (entry_side[i]) begin
            entry_side[i] = 1'($urandom_range(1));
            entry_from[i] = t_square'($urandom_range(63));
            entry_to[i]   = t_square'($urandom_range(63));
        end

        i_rst_n             <= 1'b0;
        item_if.valid       <= 1'b0;
        item_if.kind        <= KIND_RECORD;
        item_if.move_code   <= '0;
        item_if.side        <= 1'b0;
        item_if.from_square <= '0;
        item_if.to_square   <= '0;
        item_if.ply         <= '0;
        item_if.depth       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass after reset shows up as ready held low

        // directed: empty slots, zero depth, field extremes, killer shifting
        // empty slot never matches, move code zero included
        apply_item(mk_item(KIND_QUERY, '0, 1'b0, '0, '0, '0, '0));
        // zero depth: history untouched, killer still filled
        apply_item(mk_item(KIND_RECORD, '0, 1'b0, '0, '0, '0, '0));
        apply_item(mk_item(KIND_QUERY, '0, 1'b0, '0, '0, '0, '0));
        apply_item(mk_item(KIND_QUERY, 16'h0001, 1'b0, '0, '0, '0, '1));
        // all-ones fields
        apply_item(mk_item(KIND_RECORD, '1, 1'b1, '1, '1, '1, '1));
        apply_item(mk_item(KIND_QUERY, '1, 1'b1, '1, '1, '1, '1));
        // new first killer pushes the old one to second
        apply_item(mk_item(KIND_RECORD, 16'h1234, 1'b1, '1, '1, '1, 6'd5));
        apply_item(mk_item(KIND_QUERY, '1, 1'b1, '1, '1, '1, '0));
        apply_item(mk_item(KIND_QUERY, 16'h1234, 1'b1, '1, '1, '1, '0));
        // same move again: pair unchanged, history still grows
        apply_item(mk_item(KIND_RECORD, 16'h1234, 1'b1, '1, '1, '1, 6'd3));
        apply_item(mk_item(KIND_QUERY, '1, 1'b1, '1, '1, '1, '0));
        apply_item(mk_item(KIND_QUERY, 16'hABCD, 1'b1, '1, '1, '1, '0));
        // third move drops the oldest killer
        apply_item(mk_item(KIND_RECORD, 16'h5555, 1'b1, '1, '1, '1, 6'd1));
        apply_item(mk_item(KIND_QUERY, '1, 1'b1, '1, '1, '1, '0));
        apply_item(mk_item(KIND_QUERY, 16'h1234, 1'b1, '1, '1, '1, '0));
        // other side half and other ply are separate
        apply_item(mk_item(KIND_QUERY, 16'hABCD, 1'b0, '1, '1, '1, '0));
        apply_item(mk_item(KIND_QUERY, 16'h5555, 1'b1, '1, '1, 6'd62, '0));
        apply_item(mk_item(KIND_RECORD, 16'hAAAA, 1'b0, 6'h2A, 6'h15, 6'h15, 6'h2A));
        apply_item(mk_item(KIND_QUERY, 16'h5555, 1'b0, 6'h2A, 6'h15, 6'h15, 6'h15));
        apply_item(mk_item(KIND_QUERY, 16'hAAAA, 1'b0, 6'h15, 6'h2A, 6'h15, 6'h15));

        // random phases over the idling patterns
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = send_idle_by_phase[p];
            receiver_stall_pct = recv_stall_by_phase[p];
            repeat (107) apply_item(rand_item());
        end
        item_if.valid <= 1'b0;

        while (sb.expected_priorities.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_priorities.size() == 0) begin
            $display("[killer_history_move_table] OK");
        end else begin
            $display("[killer_history_move_table] ERROR");
        end
        $finish;
    end

endmodule

[killer_history_move_table.f]
+incdir+rtl
rtl/kht_pkg.sv
rtl/kht_if.sv
rtl/kht_ram.sv
rtl/killer_history_move_table.sv
dv/killer_history_move_table_test.sv
